// ----- rtl/core/tfw_pkg.sv -----
// shared types, constants and a helper function of the tf-idf weighting block
package tfw_pkg;

	localparam int TFW_MAX_DOCS   = 1024;
	localparam int TFW_MAX_TERMS  = 4096;
	localparam int TFW_COUNT_BITS = 16;
	localparam int TFW_FRAC_BITS  = 16;

	localparam int FREQ_W   = 11;
	localparam int NDOCS_W  = 11;
	localparam int TOTAL_W  = 32;
	localparam int LOG_FRAC = 28;
	localparam int LN24_W   = 28;

	localparam logic [FREQ_W-1:0] FREQ_MAX = 11'd2047;
	localparam logic [31:0]       LN2_Q32  = 32'd2977044472;

	// input commands
	localparam logic [1:0] CMD_ACC   = 2'd0;
	localparam logic [1:0] CMD_WEIGH = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_IDX = 2'd1;
	localparam logic [1:0] ST_NO_STAT = 2'd2;

	// configuration register indexes
	localparam logic REG_NUM_DOCS  = 1'b0;
	localparam logic REG_USE_TFIDF = 1'b1;

	typedef enum logic [1:0] {
		OP_ACC,
		OP_WEIGH,
		OP_CLEAR,
		OP_BAD
	} op_t;

	typedef struct packed {
		logic clearing;
		logic idle;
	} bk_stat_t;

	// index of the highest set bit
	function automatic logic [3:0] msb_idx(input logic [NDOCS_W-1:0] v);
		logic [3:0] k;
		k = '0;
		for (int i = 1; i < NDOCS_W; i++) begin
			if (v[i]) k = 4'(i);
		end
		return k;
	endfunction

endpackage

// ----- rtl/core/tfw_front.sv -----
// front end: accepts items, checks indexes, classifies and queues them
module tfw_front import tfw_pkg::*; #(
	parameter int MAX_DOCS   = TFW_MAX_DOCS,
	parameter int MAX_TERMS  = TFW_MAX_TERMS,
	parameter int COUNT_BITS = TFW_COUNT_BITS,
	parameter int DAW        = $clog2(MAX_DOCS),
	parameter int TAW        = $clog2(MAX_TERMS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [39:0]           s_tdata,   // cmd, doc_index, term_index, term_count
	input  logic [NDOCS_W-1:0]    num_docs,
	input  logic                  hold,
	output logic                  q_valid,
	input  logic                  q_pop,
	output op_t                   q_kind,
	output logic [DAW-1:0]        q_doc,
	output logic [TAW-1:0]        q_term,
	output logic [COUNT_BITS-1:0] q_count
);

	logic [1:0]  cmd;
	logic [9:0]  doc_in;
	logic [11:0] term_in;
	logic [15:0] cnt_in;
	logic [31:0] doc_ext, term_ext, cnt_ext;
	logic        bad, push, acc;
	op_t         kind;

	op_t                  kind_q  [2];
	logic [DAW-1:0]       doc_q   [2];
	logic [TAW-1:0]       term_q  [2];
	logic [COUNT_BITS-1:0] cnt_q  [2];
	logic                 wp_q, rp_q;
	logic [1:0]           fill_q;

	assign cmd     = s_tdata[1:0];
	assign doc_in  = s_tdata[11:2];
	assign term_in = s_tdata[23:12];
	assign cnt_in  = s_tdata[39:24];
	assign doc_ext  = 32'(doc_in);
	assign term_ext = 32'(term_in);
	assign cnt_ext  = 32'(cnt_in);

	assign bad = (doc_ext >= 32'(num_docs)) || (doc_ext >= 32'(MAX_DOCS))
		|| (term_ext >= 32'(MAX_TERMS));

	always_comb begin
		kind = OP_ACC;
		unique case (cmd)
			CMD_ACC:   kind = bad ? OP_BAD : OP_ACC;
			CMD_WEIGH: kind = bad ? OP_BAD : OP_WEIGH;
			CMD_CLEAR: kind = OP_CLEAR;
			default:   kind = OP_ACC;
		endcase
	end

	assign s_tready = (fill_q != 2'd2) && !hold;
	assign acc      = s_tvalid && s_tready;
	// the unused command is dropped here
	assign push     = acc && (cmd != CMD_NONE);

	assign q_valid = (fill_q != 2'd0);
	assign q_kind  = kind_q[rp_q];
	assign q_doc   = doc_q[rp_q];
	assign q_term  = term_q[rp_q];
	assign q_count = cnt_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wp_q] <= kind;
			doc_q[wp_q]  <= doc_ext[DAW-1:0];
			term_q[wp_q] <= term_ext[TAW-1:0];
			cnt_q[wp_q]  <= cnt_ext[COUNT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			fill_q <= fill_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ----- rtl/core/tfw_back.sv -----
// back end: statistics stores, log and divide sequencer, output register
module tfw_back import tfw_pkg::*; #(
	parameter int MAX_DOCS   = TFW_MAX_DOCS,
	parameter int MAX_TERMS  = TFW_MAX_TERMS,
	parameter int COUNT_BITS = TFW_COUNT_BITS,
	parameter int FRAC_BITS  = TFW_FRAC_BITS,
	parameter int DAW        = $clog2(MAX_DOCS),
	parameter int TAW        = $clog2(MAX_TERMS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [NDOCS_W-1:0]    num_docs,
	input  logic                  use_tfidf,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  op_t                   q_kind,
	input  logic [DAW-1:0]        q_doc,
	input  logic [TAW-1:0]        q_term,
	input  logic [COUNT_BITS-1:0] q_count,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,   // weight, status, zero fill
	output bk_stat_t              stat
);

	localparam int CW    = COUNT_BITS;
	localparam int SH    = 24 - FRAC_BITS;
	localparam int DW    = TOTAL_W + SH;
	localparam int NW    = CW + LN24_W;
	localparam int NPW   = (NW > 32) ? NW : 33;
	localparam int CLR_N = (MAX_DOCS > MAX_TERMS) ? MAX_DOCS : MAX_TERMS;
	localparam int CLW   = $clog2(CLR_N);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_EVAL, S_LOG, S_LN, S_MUL, S_CHK, S_DIV, S_DONE
	} state_t;

	state_t state_q;

	logic [FREQ_W-1:0]  freq_mem [MAX_TERMS];
	logic [TOTAL_W-1:0] tot_mem  [MAX_DOCS];
	logic [FREQ_W-1:0]  freq_rd_q;
	logic [TOTAL_W-1:0] tot_rd_q;

	op_t             kind_q;
	logic [DAW-1:0]  doc_q;
	logic [TAW-1:0]  term_q;
	logic [CW-1:0]   cnt_q;
	logic [CLW-1:0]  clr_q;
	logic [4:0]      step_q;
	logic [30:0]     mn_q, md_q;
	logic [31:0]     rn_q, rd_q;
	logic [LN24_W-1:0] ln24_q;
	logic [NPW-1:0]  num_q;
	logic [DW-1:0]   rem_q;
	logic [31:0]     lo_q, quo_q;
	logic [31:0]     res_w_q;
	logic [1:0]      res_s_q;
	logic            out_v_q;
	logic [31:0]     out_w_q;
	logic [1:0]      out_s_q;

	// memory write port
	logic               wr_en;
	logic [DAW-1:0]     wr_doc;
	logic [TAW-1:0]     wr_term;
	logic [TOTAL_W-1:0] wr_tot;
	logic [FREQ_W-1:0]  wr_freq;

	logic [32:0]        acc_sum;
	logic [63:0]        pass_w;
	logic [3:0]         kn, kd;
	logic [61:0]        sqn, sqd;
	logic [31:0]        sqn_t, sqd_t;
	logic [31:0]        dlog;
	logic [63:0]        ln_prod;
	logic [DW-1:0]      den;
	logic [NPW-33:0]    num_hi;
	logic [DW:0]        trial;
	logic               out_free;

	assign acc_sum = 33'(tot_rd_q) + 33'(cnt_q);
	assign pass_w  = 64'(cnt_q) << FRAC_BITS;
	assign kn      = msb_idx(num_docs);
	assign kd      = msb_idx(freq_rd_q);
	assign sqn     = 62'(mn_q) * 62'(mn_q);
	assign sqd     = 62'(md_q) * 62'(md_q);
	assign sqn_t   = sqn[61:30];
	assign sqd_t   = sqd[61:30];
	assign dlog    = rn_q - rd_q;
	assign ln_prod = 64'(dlog) * 64'(LN2_Q32);
	assign den     = DW'(tot_rd_q) << SH;
	assign num_hi  = num_q[NPW-1:32];
	assign trial   = {rem_q, lo_q[31]};
	assign out_free = !out_v_q || m_tready;

	always_comb begin
		wr_en   = 1'b0;
		wr_doc  = doc_q;
		wr_term = term_q;
		wr_tot  = acc_sum[32] ? '1 : acc_sum[31:0];
		wr_freq = (cnt_q != '0 && freq_rd_q < FREQ_MAX) ? freq_rd_q + 1'b1 : freq_rd_q;
		if (state_q == S_CLR) begin
			wr_en   = 1'b1;
			wr_doc  = DAW'(clr_q);
			wr_term = TAW'(clr_q);
			wr_tot  = '0;
			wr_freq = '0;
		end else if (state_q == S_EVAL && kind_q == OP_ACC) begin
			wr_en = 1'b1;
		end
	end

	// read data is taken in every idle cycle and held while an item is worked on
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tot_mem[wr_doc]   <= wr_tot;
			freq_mem[wr_term] <= wr_freq;
		end
		if (state_q == S_IDLE) begin
			tot_rd_q  <= tot_mem[q_doc];
			freq_rd_q <= freq_mem[q_term];
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			step_q  <= '0;
			out_v_q <= 1'b0;
			out_w_q <= '0;
			out_s_q <= ST_OK;
			res_w_q <= '0;
			res_s_q <= ST_OK;
			kind_q  <= OP_ACC;
			doc_q   <= '0;
			term_q  <= '0;
			cnt_q   <= '0;
			mn_q    <= '0;
			md_q    <= '0;
			rn_q    <= '0;
			rd_q    <= '0;
			ln24_q  <= '0;
			num_q   <= '0;
			rem_q   <= '0;
			lo_q    <= '0;
			quo_q   <= '0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLW'(CLR_N - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) begin
						kind_q  <= q_kind;
						doc_q   <= q_doc;
						term_q  <= q_term;
						cnt_q   <= q_count;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					res_w_q <= '0;
					res_s_q <= ST_OK;
					state_q <= S_DONE;
					unique case (kind_q)
						OP_CLEAR: begin
							clr_q   <= '0;
							state_q <= S_CLR;
						end
						OP_BAD: res_s_q <= ST_BAD_IDX;
						OP_ACC: res_s_q <= ST_OK;
						OP_WEIGH: begin
							if (!use_tfidf) begin
								res_w_q <= (|pass_w[63:32]) ? '1 : pass_w[31:0];
							end else if (cnt_q == '0) begin
								res_w_q <= '0;
							end else if (freq_rd_q == '0 || tot_rd_q == '0) begin
								res_s_q <= ST_NO_STAT;
							end else begin
								mn_q    <= 31'(num_docs) << (5'd30 - 5'(kn));
								md_q    <= 31'(freq_rd_q) << (5'd30 - 5'(kd));
								rn_q    <= 32'(kn) << LOG_FRAC;
								rd_q    <= 32'(kd) << LOG_FRAC;
								step_q  <= 5'(LOG_FRAC - 1);
								state_q <= S_LOG;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_LOG: begin
					// one squaring step of both mantissas per cycle
					if (sqn_t[31]) begin
						mn_q <= sqn_t[31:1];
						rn_q[step_q] <= 1'b1;
					end else begin
						mn_q <= sqn_t[30:0];
					end
					if (sqd_t[31]) begin
						md_q <= sqd_t[31:1];
						rd_q[step_q] <= 1'b1;
					end else begin
						md_q <= sqd_t[30:0];
					end
					step_q <= step_q - 1'b1;
					if (step_q == '0) state_q <= S_LN;
				end
				S_LN: begin
					if (rn_q <= rd_q) begin
						// negative idf clamps to zero
						res_w_q <= '0;
						state_q <= S_DONE;
					end else begin
						ln24_q  <= ln_prod[36 +: LN24_W];
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					num_q   <= NPW'(NW'(cnt_q) * NW'(ln24_q));
					state_q <= S_CHK;
				end
				S_CHK: begin
					if ((DW+1)'(num_hi) >= (DW+1)'(den)) begin
						res_w_q <= '1;
						state_q <= S_DONE;
					end else begin
						rem_q   <= DW'(num_hi);
						lo_q    <= num_q[31:0];
						step_q  <= 5'd31;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// restoring division, one quotient bit per cycle
					if (trial >= (DW+1)'(den)) begin
						rem_q <= DW'(trial - (DW+1)'(den));
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= trial[DW-1:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					lo_q   <= {lo_q[30:0], 1'b0};
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						res_w_q <= (trial >= (DW+1)'(den)) ? {quo_q[30:0], 1'b1}
							: {quo_q[30:0], 1'b0};
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						out_w_q <= res_w_q;
						out_s_q <= res_s_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid      = out_v_q;
	assign m_tdata       = {6'd0, out_s_q, out_w_q};
	assign stat.clearing = (state_q == S_CLR);
	assign stat.idle     = (state_q == S_IDLE);

endmodule

// ----- rtl/core/tf_idf_weighting.sv -----
// top level of the tf-idf term weighting block
// Items enter on the s_ stream: cmd accumulate adds a count to the document
// total and adds one to the term document frequency, cmd weigh returns
// count/total*ln(num_docs/docfreq) in unsigned fixed point, cmd clear zeroes
// both stores. Accumulate and weigh each return one transaction on the m_
// stream with weight and status; clear and the unused command return none.
// num_docs and use_tfidf are written through cfg_we/cfg_addr/cfg_wdata.
// A tf-idf weigh runs a 28-step squaring log unit for both logarithms and
// a 32-step restoring divider; each item takes one memory read.
// A two-entry queue splits the front from the back, so items are taken
// while the back works; one item at a time goes through the back.
// After reset, and after a clear, a sweep over max(MAX_DOCS, MAX_TERMS)
// addresses (4096 by default) zeroes the stores; s_tready is low after reset
// until it ends. A stalled m_ side holds the result register and the back
// waits; the queue keeps accepting until full.
module tf_idf_weighting import tfw_pkg::*; #(
	parameter int MAX_DOCS   = TFW_MAX_DOCS,
	parameter int MAX_TERMS  = TFW_MAX_TERMS,
	parameter int COUNT_BITS = TFW_COUNT_BITS,
	parameter int FRAC_BITS  = TFW_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // cmd, doc_index, term_index, term_count
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // weight, status, zero fill
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [10:0] cfg_wdata
);

	localparam int DAW = $clog2(MAX_DOCS);
	localparam int TAW = $clog2(MAX_TERMS);

	logic [NDOCS_W-1:0]    num_docs_q;
	logic                  use_tfidf_q;
	logic                  q_valid, q_pop;
	op_t                   q_kind;
	logic [DAW-1:0]        q_doc;
	logic [TAW-1:0]        q_term;
	logic [COUNT_BITS-1:0] q_count;
	bk_stat_t              bk_stat;
	logic                  hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_docs_q  <= 11'd1;
			use_tfidf_q <= 1'b1;
			hold_q      <= 1'b1;
		end else begin
			if (cfg_we && cfg_addr == REG_NUM_DOCS) num_docs_q <= cfg_wdata;
			if (cfg_we && cfg_addr == REG_USE_TFIDF) use_tfidf_q <= cfg_wdata[0];
			// input held off only during the sweep after reset
			if (!bk_stat.clearing) hold_q <= 1'b0;
		end
	end

	tfw_front #(
		.MAX_DOCS(MAX_DOCS), .MAX_TERMS(MAX_TERMS), .COUNT_BITS(COUNT_BITS),
		.DAW(DAW), .TAW(TAW)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.num_docs(num_docs_q), .hold(hold_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_kind(q_kind),
		.q_doc(q_doc), .q_term(q_term), .q_count(q_count)
	);

	tfw_back #(
		.MAX_DOCS(MAX_DOCS), .MAX_TERMS(MAX_TERMS), .COUNT_BITS(COUNT_BITS),
		.FRAC_BITS(FRAC_BITS), .DAW(DAW), .TAW(TAW)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.num_docs(num_docs_q), .use_tfidf(use_tfidf_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_kind(q_kind),
		.q_doc(q_doc), .q_term(q_term), .q_count(q_count),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.stat(bk_stat)
	);

	a_no_accept_in_reset_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_q && bk_stat.clearing) |-> !s_tready)
		else $error("input accepted during reset sweep");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[33:32] != 2'd3))
		else $error("undefined status code");

	a_error_zero_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[33:32] != ST_OK) |-> (m_tdata[31:0] == 32'd0))
		else $error("error result with nonzero weight");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_valid && bk_stat.idle))
		else $error("queue popped outside idle");

endmodule
